>>> design/keyframe_linear_interpolator_assert.svh
// Assertion macros used by the top-level design file.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define KLI_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define KLI_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define KLI_ASSERT_IMP(label, clk, rst_n, a, b)
`define KLI_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

>>> design/kli_pkg.sv
package kli_pkg;
    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int KEY_W    = 96;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOSEG = 2'd2;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_START,
        S_CALC,
        S_DONE
    } kli_state_t;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -35'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage

>>> design/keyframe_linear_interpolator.sv
// Keyframe table of up to 64 (x, y, t) entries in one synchronous RAM. An add
// request stores a key, or answers with status FULL when the table is full. A
// query request clamps t to [0, 1.0], walks the table one key per cycle looking
// for the first segment with tA <= t < tB (status NOSEG if there is none or
// fewer than two keys are stored), then runs two serial multiply/divide units
// in parallel: shift-add multiply, then restoring division. One request is
// in flight at a time; a finished result waits in the output register.
module keyframe_linear_interpolator import kli_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // x_value[31:0], y_value[63:32], time_value[95:64]
    input  logic        s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata   // offset_x[31:0], offset_y[63:32], status[65:64], zero
);
`include "keyframe_linear_interpolator_assert.svh"

    kli_state_t state_reg, state_next;

    logic [CNT_W-1:0] key_count_reg;
    logic [IDX_W-1:0] k_reg;
    logic [31:0]      cx_reg, cy_reg, t_reg;
    logic [95:0]      prev_reg;
    logic [31:0]      pax_reg, pbx_reg, pay_reg, pby_reg;
    logic [31:0]      w_reg, d_reg;
    logic [31:0]      rx_reg, ry_reg;
    logic [1:0]       rs_reg;
    logic             m_tvalid_reg;
    logic [71:0]      m_tdata_reg;

    logic             accept, mul_start, done_x, done_y;
    logic [IDX_W-1:0] raddr;
    logic [95:0]      rdata;
    logic [31:0]      qx, qy;
    logic             full, seg_hit, last_key, out_free;
    logic signed [31:0] t_clamp;

    assign accept   = s_tvalid && s_tready;
    assign full     = key_count_reg == CNT_W'(MAX_KEYS);
    assign out_free = !m_tvalid_reg || m_tready;
    assign raddr    = (state_reg == S_SCAN) ? k_reg + IDX_W'(1) : '0;
    assign last_key = {1'b0, k_reg} == key_count_reg - CNT_W'(1);
    assign seg_hit  = (k_reg != '0)
                   && ($signed(t_reg) >= $signed(prev_reg[95:64]))
                   && ($signed(t_reg) <  $signed(rdata[95:64]));

    always_comb
    begin
        t_clamp = $signed(s_tdata[95:64]);
        if (t_clamp > $signed(Q_ONE))
            t_clamp = $signed(Q_ONE);
        else if (t_clamp < 0)
            t_clamp = '0;
    end

    kli_key_ram #(.DATA_W(KEY_W), .ADDR_W(IDX_W)) u_ram (
        .clk   (clk),
        .we    (accept && s_tuser == ACT_ADD && !full),
        .waddr (key_count_reg[IDX_W-1:0]),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // magnitude of pB - pA fits in 32 bits
    logic signed [32:0] dx, dy;
    assign dx = $signed({pbx_reg[31], pbx_reg}) - $signed({pax_reg[31], pax_reg});
    assign dy = $signed({pby_reg[31], pby_reg}) - $signed({pay_reg[31], pay_reg});

    logic [32:0] mx_full, my_full;
    assign mx_full = dx[32] ? 33'(-dx) : 33'(dx);
    assign my_full = dy[32] ? 33'(-dy) : 33'(dy);

    kli_muldiv u_mdx (
        .clk (clk), .rst_n (rst_n), .start (mul_start),
        .mag (mx_full[31:0]), .w (w_reg), .d (d_reg), .done (done_x), .q (qx)
    );
    kli_muldiv u_mdy (
        .clk (clk), .rst_n (rst_n), .start (mul_start),
        .mag (my_full[31:0]), .w (w_reg), .d (d_reg), .done (done_y), .q (qy)
    );

    logic signed [34:0] px, py, ox, oy;
    always_comb
    begin
        px = dx[32] ? 35'($signed(pax_reg)) - 35'($signed({1'b0, qx}))
                    : 35'($signed(pax_reg)) + 35'($signed({1'b0, qx}));
        py = dy[32] ? 35'($signed(pay_reg)) - 35'($signed({1'b0, qy}))
                    : 35'($signed(pay_reg)) + 35'($signed({1'b0, qy}));
        ox = px - 35'($signed(cx_reg));
        oy = py - 35'($signed(cy_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (s_tuser == ACT_ADD || key_count_reg < CNT_W'(2))
                        state_next = S_DONE;
                    else
                        state_next = S_SCAN;
                end
            S_SCAN:
                if (seg_hit)
                    state_next = S_START;
                else if (last_key)
                    state_next = S_DONE;
            S_START: state_next = S_CALC;
            S_CALC:  if (done_x) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        case (state_reg)
            S_IDLE:  s_tready  = 1'b1;
            S_START: mul_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_count_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && s_tuser == ACT_ADD && !full)
                key_count_reg <= key_count_reg + CNT_W'(1);
            if (state_reg == S_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    cx_reg <= s_tdata[31:0];
                    cy_reg <= s_tdata[63:32];
                    t_reg  <= t_clamp;
                    k_reg  <= '0;
                    rx_reg <= '0;
                    ry_reg <= '0;
                    if (s_tuser == ACT_ADD)
                        rs_reg <= full ? ST_FULL : ST_OK;
                    else
                        rs_reg <= ST_NOSEG;
                end
            S_SCAN:
            begin
                prev_reg <= rdata;
                k_reg    <= k_reg + IDX_W'(1);
                if (seg_hit)
                begin
                    pax_reg <= prev_reg[31:0];
                    pay_reg <= prev_reg[63:32];
                    pbx_reg <= rdata[31:0];
                    pby_reg <= rdata[63:32];
                    w_reg   <= t_reg - prev_reg[95:64];
                    d_reg   <= rdata[95:64] - prev_reg[95:64];
                end
            end
            S_CALC:
                if (done_x)
                begin
                    rx_reg <= sat32(ox);
                    ry_reg <= sat32(oy);
                    rs_reg <= ST_OK;
                end
            S_DONE:
                if (out_free)
                    m_tdata_reg <= {6'd0, rs_reg, ry_reg, rx_reg};
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `KLI_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, key_count_reg <= CNT_W'(MAX_KEYS))
    `KLI_ASSERT_IMP(a_units_sync, clk, rst_n, 1'b1, done_x == done_y)
    `KLI_ASSERT_NXT(a_add_count, clk, rst_n, accept && s_tuser == ACT_ADD && !full,
                    key_count_reg == $past(key_count_reg) + CNT_W'(1))
endmodule

>>> design/kli_key_ram.sv
module kli_key_ram #(
    parameter int DATA_W = 96,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> design/kli_muldiv.sv
// q = floor(mag * w / d) with w < d; shift-add multiply then restoring divide.
module kli_muldiv import kli_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] mag,
    input  logic [31:0] w,
    input  logic [31:0] d,
    output logic        done,
    output logic [31:0] q
);
    logic [63:0] prod_reg, prod_next;
    logic [31:0] mag_reg, w_reg, d_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, phase_reg, done_reg;
    logic [32:0] trial;
    logic        fits;

    always_comb
    begin
        trial = prod_reg[63:31];
        fits  = trial >= {1'b0, d_reg};
        if (!phase_reg)
            prod_next = {prod_reg[62:0], 1'b0} + (w_reg[31] ? {32'd0, mag_reg} : 64'd0);
        else if (fits)
            prod_next = {trial[31:0] - d_reg, prod_reg[30:0], 1'b1};
        else
            prod_next = {prod_reg[62:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= '0;
            mag_reg  <= mag;
            w_reg    <= w;
            d_reg    <= d;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
            w_reg    <= {w_reg[30:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign q    = prod_reg[31:0];
endmodule
